>>> sv/synth_voice_allocator_top_assert.svh
// Assertion macros for the voice allocator top level.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SYNTH_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVA_SAME_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVA_NEXT_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared widths, codes and types of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package svalloc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int VOICE_COUNT_DEF = 32;
  localparam int STAMP_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int TIME_W = 48;
  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int FROM_W = 2;
  localparam int PH_W   = 2;
  localparam int RD_W   = 26;

  // Release duration after reset.
  localparam logic [RD_W-1:0] RD_RESET = 26'd7281770;

  // Voice phase codes.
  localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PH_W-1:0] PH_HELD = 2'd1;
  localparam logic [PH_W-1:0] PH_REL  = 2'd2;

  // Command codes; any other code acts as a sweep tick.
  localparam logic [CMD_W-1:0] CMD_ON    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] EV_MUTE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_START   = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Source class of a started voice.
  localparam logic [FROM_W-1:0] FROM_IDLE  = 2'd0;
  localparam logic [FROM_W-1:0] FROM_REL   = 2'd1;
  localparam logic [FROM_W-1:0] FROM_STEAL = 2'd2;

  // Status of the selection scan.
  typedef struct packed {
    logic have_idle;
    logic have_rel;
    logic have_match;
    logic have_mute;
  } pick_flags_t;

endpackage

`default_nettype wire

>>> sv/svalloc_mem.sv
// ----------------------------------------------------------------------------
// svalloc_mem
// Voice table memory: one write port, one read port, registered read data.
// Entries never written since reset read as all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module svalloc_mem #(
  parameter int DEPTH  = svalloc_pkg::VOICE_COUNT_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 89
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] q_r;
  logic              qv_r;

  // Storage write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read of the storage.
  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem_r[raddr];
    end
  end

  // Written-since-reset marks and their registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        qv_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

`default_nettype wire

>>> sv/svalloc_pick.sv
// ----------------------------------------------------------------------------
// svalloc_pick
// Selection accumulator fed one voice entry per cycle during the scan.
// Tracks the best idle, releasing and oldest voice as seen after the sweep,
// the oldest held voice with the requested note and the last expiring voice.
// ----------------------------------------------------------------------------
`default_nettype none

module svalloc_pick #(
  parameter int IDX_W      = 5,
  parameter int STAMP_BITS = svalloc_pkg::STAMP_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            clr,
  input  wire logic                            en,
  input  wire logic [IDX_W-1:0]                idx,
  input  wire logic [svalloc_pkg::PH_W-1:0]    phase,
  input  wire logic [svalloc_pkg::KEY_W-1:0]   key,
  input  wire logic [STAMP_BITS-1:0]           order,
  input  wire logic [svalloc_pkg::TIME_W-1:0]  deadline,
  input  wire logic [svalloc_pkg::TIME_W-1:0]  time_now,
  input  wire logic [svalloc_pkg::KEY_W-1:0]   note,
  output      svalloc_pkg::pick_flags_t        flags,
  output      logic [IDX_W-1:0]                idle_idx,
  output      logic [IDX_W-1:0]                rel_idx,
  output      logic [IDX_W-1:0]                any_idx,
  output      logic [IDX_W-1:0]                match_idx,
  output      logic [STAMP_BITS-1:0]           match_order,
  output      logic [IDX_W-1:0]                mute_idx
);

  svalloc_pkg::pick_flags_t       flags_r;
  logic                           have_any_r;
  logic [IDX_W-1:0]               idle_idx_r;
  logic [STAMP_BITS-1:0]          idle_ord_r;
  logic [IDX_W-1:0]               rel_idx_r;
  logic [svalloc_pkg::TIME_W-1:0] rel_dl_r;
  logic [IDX_W-1:0]               any_idx_r;
  logic [STAMP_BITS-1:0]          any_ord_r;
  logic [IDX_W-1:0]               match_idx_r;
  logic [STAMP_BITS-1:0]          match_ord_r;
  logic [IDX_W-1:0]               mute_idx_r;

  logic expired;
  logic idle_post;
  logic rel_live;
  logic held;
  logic take_idle;
  logic take_rel;
  logic take_any;
  logic take_match;

  // Classify the entry as it stands after this item's sweep.
  always_comb begin
    expired    = (phase == svalloc_pkg::PH_REL) && (time_now >= deadline);
    idle_post  = (phase == svalloc_pkg::PH_IDLE) || expired;
    rel_live   = (phase == svalloc_pkg::PH_REL) && !expired;
    held       = (phase != svalloc_pkg::PH_IDLE) && (phase != svalloc_pkg::PH_REL);
    take_idle  = idle_post && (!flags_r.have_idle || (order < idle_ord_r));
    take_rel   = rel_live && (!flags_r.have_rel || (deadline < rel_dl_r));
    take_any   = !have_any_r || (order < any_ord_r);
    take_match = held && (key == note) && (!flags_r.have_match || (order < match_ord_r));
  end

  // Found flags.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      flags_r    <= '0;
      have_any_r <= 1'b0;
    end else if (en) begin
      flags_r.have_idle  <= flags_r.have_idle | idle_post;
      flags_r.have_rel   <= flags_r.have_rel | rel_live;
      flags_r.have_match <= flags_r.have_match | take_match;
      flags_r.have_mute  <= flags_r.have_mute | expired;
      have_any_r         <= 1'b1;
    end
  end

  // Best candidates so far; strict compares keep the lowest index on ties.
  always_ff @(posedge clk) begin
    if (en) begin
      if (take_idle) begin
        idle_idx_r <= idx;
        idle_ord_r <= order;
      end
      if (take_rel) begin
        rel_idx_r <= idx;
        rel_dl_r  <= deadline;
      end
      if (take_any) begin
        any_idx_r <= idx;
        any_ord_r <= order;
      end
      if (take_match) begin
        match_idx_r <= idx;
        match_ord_r <= order;
      end
      if (expired) begin
        mute_idx_r <= idx;
      end
    end
  end

  assign flags       = flags_r;
  assign idle_idx    = idle_idx_r;
  assign rel_idx     = rel_idx_r;
  assign any_idx     = any_idx_r;
  assign match_idx   = match_idx_r;
  assign match_order = match_ord_r;
  assign mute_idx    = mute_idx_r;

endmodule

`default_nettype wire

>>> sv/synth_voice_allocator_top.sv
// Sequence: the select scan reads every voice, then the sequencer decides. A note-on
// that mutes nothing then goes straight to the start of its voice and its result.
// A mute scan of the table runs only when some voice expires.
// Only one transaction is handled at a time.
// Reset clears all voices to idle at once through per-entry valid marks.
// Output stalls add cycles only where a result is waiting to leave.
// ----------------------------------------------------------------------------
// synth_voice_allocator_top
// Polyphonic voice allocator with stealing. The voice table sits in one
// synchronous memory; a sequencer scans it, then writes back mutes,
// releases and starts, and drives one registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_voice_allocator_top #(
  parameter int VOICE_COUNT = svalloc_pkg::VOICE_COUNT_DEF,
  parameter int STAMP_BITS  = svalloc_pkg::STAMP_BITS_DEF,
  parameter int IDX_W       = $clog2(VOICE_COUNT)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [svalloc_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [svalloc_pkg::KEY_W-1:0]     in_note,
  input  wire logic [svalloc_pkg::VEL_W-1:0]     in_velocity,
  input  wire logic [svalloc_pkg::TIME_W-1:0]    in_time_now,
  // Result channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [svalloc_pkg::KIND_W-1:0]    out_event_kind,
  output      logic [IDX_W-1:0]                  out_voice_index,
  output      logic [svalloc_pkg::KEY_W-1:0]     out_voice_note,
  output      logic [svalloc_pkg::VEL_W-1:0]     out_voice_velocity,
  output      logic [svalloc_pkg::FROM_W-1:0]    out_taken_from,
  output      logic                              out_last,
  // Configuration channel
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [svalloc_pkg::RD_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(VOICE_COUNT + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(VOICE_COUNT);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_A     = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_B     = 3'd4;
  localparam logic [2:0] S_START = 3'd5;

  typedef struct packed {
    logic [svalloc_pkg::PH_W-1:0]   phase;
    logic [svalloc_pkg::KEY_W-1:0]  key;
    logic [STAMP_BITS-1:0]          order;
    logic [svalloc_pkg::TIME_W-1:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic [2:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                ra_r, ra_nxt;
  logic                            dv_r, dv_nxt;
  logic [IDX_W-1:0]                di_r, di_nxt;
  logic [IDX_W-1:0]                last_idx_r, last_idx_nxt;
  logic                            mute_any_r, mute_any_nxt;
  logic [STAMP_BITS-1:0]           cnt_r, cnt_nxt;
  logic [svalloc_pkg::RD_W-1:0]    rd_r;

  logic [svalloc_pkg::CMD_W-1:0]   cmd_r;
  logic [svalloc_pkg::KEY_W-1:0]   note_r;
  logic [svalloc_pkg::VEL_W-1:0]   vel_r;
  logic [svalloc_pkg::TIME_W-1:0]  now_r;
  logic [svalloc_pkg::TIME_W-1:0]  dl_r;
  logic [svalloc_pkg::TIME_W:0]    dl_sum;

  logic                            out_valid_r;
  logic [svalloc_pkg::KIND_W-1:0]  out_kind_r;
  logic [IDX_W-1:0]                out_idx_r;
  logic [svalloc_pkg::KEY_W-1:0]   out_note_r;
  logic [svalloc_pkg::VEL_W-1:0]   out_vel_r;
  logic [svalloc_pkg::FROM_W-1:0]  out_from_r;
  logic                            out_last_r;

  logic                            in_accept;
  logic                            out_free;
  logic                            pick_clr;
  logic                            pick_en;
  logic                            cmd_is_on;
  logic                            cmd_is_off;
  logic                            rel_mute;
  logic                            scan_more;
  logic                            scan_done;
  logic                            b_exp;

  logic                            emit;
  logic [svalloc_pkg::KIND_W-1:0]  emit_kind;
  logic [IDX_W-1:0]                emit_idx;
  logic [svalloc_pkg::KEY_W-1:0]   emit_note;
  logic [svalloc_pkg::VEL_W-1:0]   emit_vel;
  logic [svalloc_pkg::FROM_W-1:0]  emit_from;
  logic                            emit_last;

  logic                            mem_we;
  logic [IDX_W-1:0]                mem_waddr;
  entry_t                          mem_wdata;
  logic                            mem_re;
  logic [IDX_W-1:0]                mem_raddr;
  entry_t                          mem_rdata;

  svalloc_pkg::pick_flags_t        flags;
  logic [IDX_W-1:0]                idle_idx;
  logic [IDX_W-1:0]                rel_idx;
  logic [IDX_W-1:0]                any_idx;
  logic [IDX_W-1:0]                match_idx;
  logic [STAMP_BITS-1:0]           match_order;
  logic [IDX_W-1:0]                mute_idx;
  logic [IDX_W-1:0]                start_idx;
  logic [svalloc_pkg::FROM_W-1:0]  start_from;

  // Voice table memory.
  svalloc_mem #(
    .DEPTH  (VOICE_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Selection accumulator, fed during the first scan only.
  svalloc_pick #(
    .IDX_W      (IDX_W),
    .STAMP_BITS (STAMP_BITS)
  ) u_pick (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (pick_clr),
    .en          (pick_en),
    .idx         (di_r),
    .phase       (mem_rdata.phase),
    .key         (mem_rdata.key),
    .order       (mem_rdata.order),
    .deadline    (mem_rdata.deadline),
    .time_now    (now_r),
    .note        (note_r),
    .flags       (flags),
    .idle_idx    (idle_idx),
    .rel_idx     (rel_idx),
    .any_idx     (any_idx),
    .match_idx   (match_idx),
    .match_order (match_order),
    .mute_idx    (mute_idx)
  );

  // Handshake terms.
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign cmd_is_on  = (cmd_r == svalloc_pkg::CMD_ON);
  assign cmd_is_off = (cmd_r == svalloc_pkg::CMD_OFF);
  assign pick_en    = (state_r == S_A) && dv_r;
  assign scan_more  = (ra_r < SCAN_END);
  assign scan_done  = (ra_r == SCAN_END) && !dv_r;
  assign b_exp      = dv_r && (mem_rdata.phase == svalloc_pkg::PH_REL) &&
                      (now_r >= mem_rdata.deadline);
  assign rel_mute   = cmd_is_off && flags.have_match && (now_r >= dl_r);

  // Release deadline, saturated at the top of the time range.
  assign dl_sum = {1'b0, in_time_now} +
                  {{(svalloc_pkg::TIME_W + 1 - svalloc_pkg::RD_W){1'b0}}, rd_r};

  // Voice chosen for a note-on, in order of preference.
  always_comb begin
    if (flags.have_idle) begin
      start_idx  = idle_idx;
      start_from = svalloc_pkg::FROM_IDLE;
    end else if (flags.have_rel) begin
      start_idx  = rel_idx;
      start_from = svalloc_pkg::FROM_REL;
    end else begin
      start_idx  = any_idx;
      start_from = svalloc_pkg::FROM_STEAL;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    ra_nxt       = ra_r;
    dv_nxt       = dv_r;
    di_nxt       = di_r;
    last_idx_nxt = last_idx_r;
    mute_any_nxt = mute_any_r;
    cnt_nxt      = cnt_r;
    pick_clr     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ra_r[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = di_r;
    mem_wdata    = mem_rdata;
    emit         = 1'b0;
    emit_kind    = svalloc_pkg::EV_MUTE;
    emit_idx     = di_r;
    emit_note    = '0;
    emit_vel     = '0;
    emit_from    = svalloc_pkg::FROM_IDLE;
    emit_last    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ra_nxt    = '0;
          dv_nxt    = 1'b0;
          pick_clr  = 1'b1;
          state_nxt = S_A;
        end
      end
      S_A: begin
        mem_re = scan_more;
        ra_nxt = ra_r + CNT_W'(scan_more);
        dv_nxt = scan_more;
        di_nxt = ra_r[IDX_W-1:0];
        if (scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // The released voice is also muted when its deadline is already due.
        if (rel_mute && (!flags.have_mute || (match_idx > mute_idx))) begin
          last_idx_nxt = match_idx;
        end else begin
          last_idx_nxt = mute_idx;
        end
        mute_any_nxt = flags.have_mute || rel_mute;
        ra_nxt       = '0;
        dv_nxt       = 1'b0;
        if (cmd_is_off && flags.have_match) begin
          state_nxt = S_REL;
        end else if (flags.have_mute) begin
          state_nxt = S_B;
        end else if (cmd_is_on) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REL: begin
        if (out_free) begin
          mem_we             = 1'b1;
          mem_waddr          = match_idx;
          mem_wdata.phase    = svalloc_pkg::PH_REL;
          mem_wdata.key      = note_r;
          mem_wdata.order    = match_order;
          mem_wdata.deadline = dl_r;
          emit               = 1'b1;
          emit_kind          = svalloc_pkg::EV_RELEASE;
          emit_idx           = match_idx;
          emit_note          = note_r;
          emit_last          = !mute_any_r;
          state_nxt          = mute_any_r ? S_B : S_IDLE;
        end
      end
      S_B: begin
        // The scan holds while an expired voice waits for the result register.
        if (!b_exp || out_free) begin
          mem_re = scan_more;
          ra_nxt = ra_r + CNT_W'(scan_more);
          dv_nxt = scan_more;
          di_nxt = ra_r[IDX_W-1:0];
        end
        if (b_exp && out_free) begin
          mem_we          = 1'b1;
          mem_waddr       = di_r;
          mem_wdata.phase = svalloc_pkg::PH_IDLE;
          emit            = 1'b1;
          emit_kind       = svalloc_pkg::EV_MUTE;
          emit_idx        = di_r;
          emit_last       = !cmd_is_on && (di_r == last_idx_r);
        end
        if (scan_done) begin
          state_nxt = cmd_is_on ? S_START : S_IDLE;
        end
      end
      S_START: begin
        if (out_free) begin
          cnt_nxt            = cnt_r + STAMP_BITS'(1);
          mem_we             = 1'b1;
          mem_waddr          = start_idx;
          mem_wdata.phase    = svalloc_pkg::PH_HELD;
          mem_wdata.key      = note_r;
          mem_wdata.order    = cnt_nxt;
          mem_wdata.deadline = '0;
          emit               = 1'b1;
          emit_kind          = svalloc_pkg::EV_START;
          emit_idx           = start_idx;
          emit_note          = note_r;
          emit_vel           = vel_r;
          emit_from          = start_from;
          emit_last          = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ra_r       <= '0;
      dv_r       <= 1'b0;
      mute_any_r <= 1'b0;
      cnt_r      <= '0;
      rd_r       <= svalloc_pkg::RD_RESET;
    end else begin
      state_r    <= state_nxt;
      ra_r       <= ra_nxt;
      dv_r       <= dv_nxt;
      mute_any_r <= mute_any_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        rd_r <= cfg_data;
      end
    end
  end

  // Scan index and captured input transaction.
  always_ff @(posedge clk) begin
    di_r       <= di_nxt;
    last_idx_r <= last_idx_nxt;
    if (in_accept) begin
      cmd_r  <= in_cmd;
      note_r <= in_note;
      vel_r  <= in_velocity;
      now_r  <= in_time_now;
      dl_r   <= dl_sum[svalloc_pkg::TIME_W] ? {svalloc_pkg::TIME_W{1'b1}} :
                dl_sum[svalloc_pkg::TIME_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_idx_r  <= emit_idx;
      out_note_r <= emit_note;
      out_vel_r  <= emit_vel;
      out_from_r <= emit_from;
      out_last_r <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_voice_index    = out_idx_r;
  assign out_voice_note     = out_note_r;
  assign out_voice_velocity = out_vel_r;
  assign out_taken_from     = out_from_r;
  assign out_last           = out_last_r;

  // Assertions.
`include "synth_voice_allocator_top_assert.svh"

  `SVA_NEXT_CYCLE(a_accept_scan, in_accept, state_r == S_A, "no scan after accept")
  `SVA_SAME_CYCLE(a_emit_free, emit, out_free, "result loaded over a waiting transaction")
  `SVA_SAME_CYCLE(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr, "read-write clash")
  `SVA_NEXT_CYCLE(a_start_last, state_r == S_START && out_free, out_valid && out_last, "no last")

endmodule

`default_nettype wire
